/* rtl/core/bav_pkg.sv */
// ----------------------------------------------------------------------------
// bav_pkg
// Shared types and constants of the bump allocator with reuse table.
// ----------------------------------------------------------------------------
package bav_pkg;

    // table and region geometry
    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int OFF_W         = 20;
    localparam int TOT_W         = 21;
    localparam logic [TOT_W-1:0] REGION_BYTES = TOT_W'(1 * 1024 * 1024);

    // stream word layout
    localparam int S_DATA_W = 40;
    localparam int S_USER_W = 3;
    localparam int M_DATA_W = 88;
    localparam int M_USER_W = 3;

    // request kinds
    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_QUERY   = 2'd2
    } t_req;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_LOCKED   = 3'd1,
        ST_ZERO     = 3'd2,
        ST_SPACE    = 3'd3,
        ST_FULL     = 3'd4,
        ST_NOTFOUND = 3'd5,
        ST_DOUBLE   = 3'd6,
        ST_NULL     = 3'd7
    } t_status;

    // one table entry, 43 bits
    typedef struct packed {
        logic             used;
        logic [OFF_W-1:0] base;
        logic [OFF_W-1:0] size;
        logic             released;
        logic             reused;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // what the compare unit is asked to look for
    typedef struct packed {
        logic             is_alloc;
        logic [OFF_W-1:0] size;
        logic [OFF_W-1:0] offset;
    } t_probe;

endpackage

/* rtl/core/bump_allocator_with_reuse_table.sv */
// ----------------------------------------------------------------------------
// bump_allocator_with_reuse_table
// Bump-pointer allocator over a byte region with an entry table whose
// released entries of equal size are handed out again at their old base.
//
//   channel   dir  handshake          payload
//   s (req)   in   i_s_tvalid/o_s_tready  tdata: alloc_size, target_offset
//                                      tuser: req_type, target_is_null
//   m (res)   out  o_m_tvalid/i_m_tready  tdata: granted_offset .. bytes_released
//                                      tuser: status
//   cfg       in   i_cfg_wr_en         alloc_locked
//
// Release, query and allocate that passes its checks scan the used part of
// the table one entry per cycle through the single RAM read port. Rejected
// requests skip the scan and go straight to the finish step.
// Reset is synchronous; a fill count marks the used prefix of the table, so
// no clearing pass is needed. A new request is taken while a finished result
// waits in the output register; its own result waits until that one is taken.
// ----------------------------------------------------------------------------
module bump_allocator_with_reuse_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [19:0] alloc_size, [39:20] target_offset
    input  logic [bav_pkg::S_DATA_W-1:0]  i_s_tdata,
    // [1:0] req_type, [2] target_is_null
    input  logic [bav_pkg::S_USER_W-1:0]  i_s_tuser,
    // result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [19:0] granted_offset, [20] was_reused, [40:21] queried_size,
    // [61:41] bytes_allocated, [82:62] bytes_released, [87:83] zero
    output logic [bav_pkg::M_DATA_W-1:0]  o_m_tdata,
    // [2:0] status
    output logic [bav_pkg::M_USER_W-1:0]  o_m_tuser,
    // configuration
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_wr_data
);
    import bav_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_ACT,
        S_FIN
    } t_state;

    t_state           r_state;
    logic             r_locked;
    logic [CNT_W-1:0] r_fill;
    logic [OFF_W-1:0] r_bump_ptr;
    logic [TOT_W-1:0] r_tot_alloc;
    logic [TOT_W-1:0] r_tot_rel;

    // request and scan registers
    logic [1:0]       r_req;
    t_probe           r_probe;
    logic [CNT_W-1:0] r_idx;
    logic             r_dv;
    logic [IDX_W-1:0] r_eidx;
    logic             r_new;
    t_entry           r_ent;

    // pending result
    t_status          r_st;
    logic [OFF_W-1:0] r_granted;
    logic             r_reused;
    logic [OFF_W-1:0] r_qsize;

    // output register
    logic                r_m_valid;
    logic [M_DATA_W-1:0] r_m_data;
    logic [M_USER_W-1:0] r_m_user;

    // request fields
    logic [1:0]       s_req;
    logic [OFF_W-1:0] s_size;
    logic [OFF_W-1:0] s_off;
    logic             s_null;
    logic [TOT_W-1:0] s_sum;
    logic             s_acc;

    // ram and compare signals
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    t_entry           ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    t_entry           ram_rdata;
    logic             cmp_hit;

    assign s_req  = i_s_tuser[1:0];
    assign s_null = i_s_tuser[2];
    assign s_size = i_s_tdata[OFF_W-1:0];
    assign s_off  = i_s_tdata[2*OFF_W-1:OFF_W];
    assign s_sum  = {1'b0, r_bump_ptr} + {1'b0, s_size};
    assign s_acc  = i_s_tvalid && o_s_tready;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

    // entry table
    bav_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // shared entry compare
    bav_cmp u_cmp (
        .i_entry (ram_rdata),
        .i_probe (r_probe),
        .o_hit   (cmp_hit)
    );

    // table write port, used only in the action step
    always_comb begin
        ram_raddr = r_idx[IDX_W-1:0];
        ram_waddr = r_eidx;
        ram_we    = 1'b0;
        ram_wdata = r_ent;
        if (r_state == S_ACT) begin
            if (r_probe.is_alloc) begin
                ram_we = 1'b1;
                if (r_new) begin
                    ram_wdata.used     = 1'b1;
                    ram_wdata.base     = r_bump_ptr;
                    ram_wdata.size     = r_probe.size;
                    ram_wdata.released = 1'b0;
                    ram_wdata.reused   = 1'b0;
                end else begin
                    ram_wdata.released = 1'b0;
                    ram_wdata.reused   = 1'b1;
                end
            end else if (r_req == REQ_RELEASE && !r_ent.released) begin
                ram_we             = 1'b1;
                ram_wdata.released = 1'b1;
            end
        end
    end

    // sequencer, totals and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_locked    <= 1'b0;
            r_fill      <= '0;
            r_bump_ptr  <= '0;
            r_tot_alloc <= '0;
            r_tot_rel   <= '0;
            r_dv        <= 1'b0;
            r_m_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_locked <= i_cfg_wr_data;
            end

            // output word valid: loaded from the finish step, cleared when taken
            if (r_state == S_FIN && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_tready) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (s_acc) begin
                        r_req            <= s_req;
                        r_probe.is_alloc <= (s_req == REQ_ALLOC);
                        r_probe.size     <= s_size;
                        r_probe.offset   <= s_off;
                        r_granted        <= '0;
                        r_reused         <= 1'b0;
                        r_qsize          <= '0;
                        r_idx            <= '0;
                        r_dv             <= 1'b0;
                        case (s_req) inside
                            REQ_ALLOC: begin
                                if (r_locked) begin
                                    r_st    <= ST_LOCKED;
                                    r_state <= S_FIN;
                                end else if (s_size == '0) begin
                                    r_st    <= ST_ZERO;
                                    r_state <= S_FIN;
                                end else if (s_sum >= REGION_BYTES) begin
                                    r_st    <= ST_SPACE;
                                    r_state <= S_FIN;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_state <= S_SCAN;
                                end
                            end
                            REQ_RELEASE, REQ_QUERY: begin
                                if (s_null) begin
                                    r_st    <= ST_NULL;
                                    r_state <= S_FIN;
                                end else begin
                                    r_st    <= ST_OK;
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                r_st    <= ST_OK;
                                r_state <= S_FIN;
                            end
                        endcase
                    end
                end

                S_SCAN: begin
                    // test the entry read last cycle while the next read is issued
                    if (r_dv && cmp_hit) begin
                        r_ent   <= ram_rdata;
                        r_new   <= 1'b0;
                        r_dv    <= 1'b0;
                        r_state <= S_ACT;
                    end else if (!r_dv && r_idx >= r_fill) begin
                        if (r_probe.is_alloc) begin
                            if (r_fill < CNT_W'(TABLE_ENTRIES)) begin
                                r_eidx  <= r_fill[IDX_W-1:0];
                                r_new   <= 1'b1;
                                r_state <= S_ACT;
                            end else begin
                                r_st    <= ST_FULL;
                                r_state <= S_FIN;
                            end
                        end else begin
                            r_st    <= ST_NOTFOUND;
                            r_state <= S_FIN;
                        end
                    end else if (r_idx < r_fill) begin
                        r_idx  <= r_idx + 1'b1;
                        r_eidx <= r_idx[IDX_W-1:0];
                        r_dv   <= 1'b1;
                    end else begin
                        r_dv <= 1'b0;
                    end
                end

                S_ACT: begin
                    r_state <= S_FIN;
                    if (r_probe.is_alloc) begin
                        if (r_new) begin
                            r_granted   <= r_bump_ptr;
                            r_bump_ptr  <= r_bump_ptr + r_probe.size;
                            r_tot_alloc <= r_tot_alloc + {1'b0, r_probe.size};
                            r_fill      <= r_fill + 1'b1;
                        end else begin
                            r_granted <= r_ent.base;
                            r_reused  <= 1'b1;
                        end
                    end else if (r_req == REQ_QUERY) begin
                        r_qsize <= r_ent.size;
                    end else if (r_ent.released) begin
                        r_st <= ST_DOUBLE;
                    end else if (!r_ent.reused) begin
                        r_tot_rel <= r_tot_rel + {1'b0, r_ent.size};
                    end
                end

                S_FIN: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_user  <= r_st;
                        r_m_data  <= {5'b0, r_tot_rel, r_tot_alloc, r_qsize,
                                      r_reused, r_granted};
                        r_state   <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/bav_ram.sv */
// ----------------------------------------------------------------------------
// bav_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bav_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* rtl/core/bav_cmp.sv */
// ----------------------------------------------------------------------------
// bav_cmp
// Shared compare unit: tests one table entry against the current request.
// ----------------------------------------------------------------------------
module bav_cmp (
    input  bav_pkg::t_entry i_entry,
    input  bav_pkg::t_probe i_probe,
    output logic            o_hit
);
    import bav_pkg::*;

    // allocate wants a released entry of the same size, lookup wants the base
    always_comb begin
        if (i_probe.is_alloc) begin
            o_hit = i_entry.used && i_entry.released && (i_entry.size == i_probe.size);
        end else begin
            o_hit = i_entry.used && (i_entry.base == i_probe.offset);
        end
    end

endmodule
